FILE: rtl/cfra_pkg.sv
package cfra_pkg;

  // Defaults for the top-level parameters
  localparam int WORD_W_DEF    = 64;
  localparam int MAX_TERMS_DEF = 64;

  // Fixed field widths
  localparam int VAL_W  = 64;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 62;
  localparam int DIV_W  = 64;
  localparam int EXP_W  = 12;
  localparam int MANT_W = 53;
  localparam int FRAC_W = 52;

  // binary64 decode constants
  localparam logic [10:0] EXPF_SPECIAL = 11'h7ff;
  localparam int          EXP_SUBNORM  = -1074;
  localparam int          EXP_BIAS     = 1075;

  // Bound after reset: largest signed 32-bit value
  localparam logic [DEN_W-1:0] MD_RESET = DEN_W'(32'h7fff_ffff);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_ZERO_T,
    OP_SHL,
    OP_SHR,
    OP_TRUNC_SET,
    OP_CF_INIT,
    OP_TERM,
    OP_X_A,
    OP_X_DIV,
    OP_X_ZERO,
    OP_SET_LAST,
    OP_H,
    OP_K,
    OP_OUT
  } dp_op_e;

  typedef enum logic {
    DIV_TERM,
    DIV_BOUND
  } div_sel_e;

  typedef enum logic [1:0] {
    MUL_A_K1,
    MUL_X_H1,
    MUL_X_K1
  } mul_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     div_start;
    div_sel_e div_sel;
    logic     mul_start;
    mul_sel_e mul_sel;
  } cmd_t;

  typedef struct packed {
    logic infnan;
    logic trunc;
    logic m_zero;
    logic e_neg;
    logic e_zero;
    logic e_ge_lim;
    logic m_wide;
    logic e_big;
    logic lsb;
    logic shl_ovf;
    logic nchk_err;
    logic n_zero;
    logic a_zero;
    logic i_zero;
    logic i_last;
    logic over;
    logic x_ok;
    logic last_ok;
    logic last_q;
    logic div_done;
    logic mul_done;
  } status_t;

endpackage

FILE: rtl/cfra_div.sv
module cfra_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cfra_pkg::DIV_W-1:0] num_i,
  input  logic [cfra_pkg::DIV_W-1:0] den_i,
  output logic                       done_o,
  output logic [cfra_pkg::DIV_W-1:0] quo_o,
  output logic [cfra_pkg::DIV_W-1:0] rem_o
);

  localparam int DW = cfra_pkg::DIV_W;
  localparam int CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, quo_q, den_q;
  logic [DW:0]   shifted, diff;

  // One quotient bit per cycle, restoring
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign quo_o   = quo_q;
  assign rem_o   = rem_q;

  // Track the running step; flag done once the last bit has landed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/cfra_mul.sv
module cfra_mul #(
  parameter int W = cfra_pkg::WORD_W_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int H = (W + 1) / 2;

  logic           busy_q;
  logic [2:0]     step_q;
  logic [1:0]     sh_q;
  logic [2*H-1:0] a_q, b_q, pp_q;
  logic [4*H-1:0] acc_q, term;
  logic [H-1:0]   half_a, half_b;
  logic [1:0]     idx;

  // Pick the halves for this partial product
  assign idx    = step_q[1:0];
  assign half_a = idx[1] ? a_q[2*H-1:H] : a_q[H-1:0];
  assign half_b = idx[0] ? b_q[2*H-1:H] : b_q[H-1:0];
  assign done_o = busy_q && (step_q == 3'd4);
  assign prod_o = acc_q[2*W-1:0];

  // Align the registered partial product
  always_comb begin
    case (sh_q)
      2'd0:    term = (4*H)'(pp_q);
      2'd3:    term = (4*H)'(pp_q) << (2 * H);
      default: term = (4*H)'(pp_q) << H;
    endcase
  end

  // Sequence the four partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Multiply into pp_q, then accumulate it in the next cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= (2*H)'(a_i);
      b_q   <= (2*H)'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (!step_q[2]) begin
        pp_q <= (2*H)'(half_a) * (2*H)'(half_b);
        sh_q <= idx;
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + term;
      end
    end
  end

endmodule

FILE: rtl/cfra_dp.sv
module cfra_dp #(
  parameter int W         = cfra_pkg::WORD_W_DEF,
  parameter int MAX_TERMS = cfra_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfra_pkg::cmd_t                    cmd_i,
  output cfra_pkg::status_t                 st_o,
  input  logic [cfra_pkg::VAL_W-1:0]        value_bits_i,
  input  logic [cfra_pkg::DEN_W-1:0]        md_i,
  output logic signed [cfra_pkg::NUM_W-1:0] numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]        denominator_o,
  output logic                              range_error_o
);

  localparam int EW = cfra_pkg::EXP_W;
  localparam int DW = cfra_pkg::DIV_W;
  localparam int NW = cfra_pkg::NUM_W;
  localparam int IW = $clog2(MAX_TERMS + 1);
  localparam int PW = 2 * W + 1;
  localparam logic signed [EW-1:0] E_LIM  = EW'(W - 1);
  localparam logic signed [EW-1:0] E_BIG  = EW'(-cfra_pkg::MANT_W);
  localparam logic signed [EW-1:0] E_NMIN = EW'(2 - W);

  logic                 neg_q, infnan_q, err_q, last_q;
  logic [63:0]          mq_q;
  logic signed [EW-1:0] e_q, e_load;
  logic [W-1:0]         d_q, n_q, a_q, x_q, h0_q, h1_q, k0_q, k1_q;
  logic [IW-1:0]        i_q;
  logic [NW-1:0]        num_q;
  logic [cfra_pkg::DEN_W-1:0] den_q;
  logic                 rerr_q;

  logic [10:0]          expf;
  logic [63:0]          m_load;
  logic [EW-1:0]        neg_e;
  logic [W-1:0]         n_init;
  logic [DW-1:0]        md_ext, k0_ext, k1_ext;
  logic [DW-1:0]        div_num, div_den, div_q, div_r;
  logic                 div_done, mul_done;
  logic [W-1:0]         mul_a, mul_b;
  logic [2*W-1:0]       mul_p;

  // Decode the binary64 pattern
  assign expf   = value_bits_i[62:52];
  assign m_load = (expf == '0) ? 64'(value_bits_i[cfra_pkg::FRAC_W-1:0])
                               : 64'({1'b1, value_bits_i[cfra_pkg::FRAC_W-1:0]});
  assign e_load = (expf == '0) ? EW'(cfra_pkg::EXP_SUBNORM)
                               : EW'(int'(expf) - cfra_pkg::EXP_BIAS);

  assign neg_e  = -e_q;
  assign n_init = W'(1) << neg_e;
  assign md_ext = DW'(md_i);
  assign k0_ext = DW'(k0_q);
  assign k1_ext = DW'(k1_q);

  // Divider operands
  always_comb begin
    unique case (cmd_i.div_sel)
      cfra_pkg::DIV_BOUND: begin
        div_num = md_ext - k0_ext;
        div_den = k1_ext;
      end
      default: begin
        div_num = DW'(d_q);
        div_den = DW'(n_q);
      end
    endcase
  end

  // Multiplier operands
  always_comb begin
    unique case (cmd_i.mul_sel)
      cfra_pkg::MUL_A_K1: begin
        mul_a = a_q;
        mul_b = k1_q;
      end
      cfra_pkg::MUL_X_H1: begin
        mul_a = x_q;
        mul_b = h1_q;
      end
      cfra_pkg::MUL_X_K1: begin
        mul_a = x_q;
        mul_b = k1_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cfra_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  cfra_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  // Status toward the controller
  always_comb begin
    st_o.infnan   = infnan_q;
    st_o.trunc    = (md_i < cfra_pkg::DEN_W'(2));
    st_o.m_zero   = (mq_q == '0);
    st_o.e_neg    = (e_q < 0);
    st_o.e_zero   = (e_q == '0);
    st_o.e_ge_lim = (e_q >= E_LIM);
    st_o.m_wide   = ((mq_q >> (W - 1)) != '0);
    st_o.e_big    = (e_q <= E_BIG);
    st_o.lsb      = mq_q[0];
    st_o.shl_ovf  = mq_q[W-2];
    st_o.nchk_err = (e_q < E_NMIN);
    st_o.n_zero   = (n_q == '0);
    st_o.a_zero   = (a_q == '0);
    st_o.i_zero   = (i_q == '0);
    st_o.i_last   = (i_q == IW'(MAX_TERMS - 1));
    st_o.over     = ({1'b0, mul_p} + PW'(k0_q)) >= PW'(md_i);
    st_o.x_ok     = (k1_q != '0) && (md_ext > k0_ext);
    st_o.last_ok  = (x_q >= a_q - x_q) || (k1_ext >= md_ext);
    st_o.last_q   = last_q;
    st_o.div_done = div_done;
    st_o.mul_done = mul_done;
  end

  // Execute the commanded operation
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cfra_pkg::OP_LOAD: begin
        neg_q    <= value_bits_i[63];
        infnan_q <= (expf == cfra_pkg::EXPF_SPECIAL);
        mq_q     <= m_load;
        e_q      <= e_load;
        err_q    <= 1'b0;
      end
      cfra_pkg::OP_ERR: begin
        h1_q  <= '0;
        k1_q  <= W'(1);
        err_q <= 1'b1;
      end
      cfra_pkg::OP_ZERO_T: begin
        h1_q <= '0;
        k1_q <= W'(1);
      end
      cfra_pkg::OP_SHL: begin
        mq_q <= mq_q << 1;
        e_q  <= e_q - EW'(1);
      end
      cfra_pkg::OP_SHR: begin
        mq_q <= mq_q >> 1;
        e_q  <= e_q + EW'(1);
      end
      cfra_pkg::OP_TRUNC_SET: begin
        h1_q <= mq_q[W-1:0];
        k1_q <= W'(1);
      end
      cfra_pkg::OP_CF_INIT: begin
        d_q    <= mq_q[W-1:0];
        n_q    <= (e_q < 0 && mq_q != '0) ? n_init : W'(1);
        h0_q   <= '0;
        h1_q   <= W'(1);
        k0_q   <= W'(1);
        k1_q   <= '0;
        i_q    <= '0;
        last_q <= 1'b0;
      end
      cfra_pkg::OP_TERM: begin
        a_q <= (n_q == '0) ? '0 : div_q[W-1:0];
        n_q <= (n_q == '0) ? '0 : div_r[W-1:0];
        d_q <= n_q;
      end
      cfra_pkg::OP_X_A: begin
        x_q    <= a_q;
        last_q <= 1'b0;
      end
      cfra_pkg::OP_X_DIV:   x_q    <= div_q[W-1:0];
      cfra_pkg::OP_X_ZERO:  x_q    <= '0;
      cfra_pkg::OP_SET_LAST: last_q <= 1'b1;
      cfra_pkg::OP_H: begin
        h0_q <= h1_q;
        h1_q <= mul_p[W-1:0] + h0_q;
      end
      cfra_pkg::OP_K: begin
        k0_q <= k1_q;
        k1_q <= mul_p[W-1:0] + k0_q;
        i_q  <= i_q + IW'(1);
      end
      cfra_pkg::OP_OUT: begin
        num_q  <= neg_q ? (NW'(0) - NW'(h1_q)) : NW'(h1_q);
        den_q  <= k1_ext[cfra_pkg::DEN_W-1:0];
        rerr_q <= err_q;
      end
      default: ;
    endcase
  end

  assign numerator_o   = num_q;
  assign denominator_o = den_q;
  assign range_error_o = rerr_q;

endmodule

FILE: rtl/cfra_ctrl.sv
module cfra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cfra_pkg::status_t st_i,
  output cfra_pkg::cmd_t    cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b0_0000_0000_0000_0001,
    S_CLASS  = 17'b0_0000_0000_0000_0010,
    S_SHL    = 17'b0_0000_0000_0000_0100,
    S_SHR    = 17'b0_0000_0000_0000_1000,
    S_STRIP  = 17'b0_0000_0000_0001_0000,
    S_TERM   = 17'b0_0000_0000_0010_0000,
    S_DIV    = 17'b0_0000_0000_0100_0000,
    S_TEST   = 17'b0_0000_0000_1000_0000,
    S_MULO   = 17'b0_0000_0001_0000_0000,
    S_OVER   = 17'b0_0000_0010_0000_0000,
    S_XDIV   = 17'b0_0000_0100_0000_0000,
    S_LAST   = 17'b0_0000_1000_0000_0000,
    S_HSTART = 17'b0_0001_0000_0000_0000,
    S_HWAIT  = 17'b0_0010_0000_0000_0000,
    S_KSTART = 17'b0_0100_0000_0000_0000,
    S_KWAIT  = 17'b0_1000_0000_0000_0000,
    S_DONE   = 17'b1_0000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath command
  always_comb begin
    state_d       = state_q;
    cmd_o.op        = cfra_pkg::OP_NONE;
    cmd_o.div_start = 1'b0;
    cmd_o.div_sel   = cfra_pkg::DIV_TERM;
    cmd_o.mul_start = 1'b0;
    cmd_o.mul_sel   = cfra_pkg::MUL_A_K1;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = cfra_pkg::OP_LOAD;
          state_d  = S_CLASS;
        end
      end
      S_CLASS: begin
        if (st_i.infnan) begin
          cmd_o.op = cfra_pkg::OP_ERR;
          state_d  = S_DONE;
        end else if (st_i.m_zero) begin
          cmd_o.op = st_i.trunc ? cfra_pkg::OP_ZERO_T : cfra_pkg::OP_CF_INIT;
          state_d  = st_i.trunc ? S_DONE : S_TERM;
        end else if (!st_i.e_neg) begin
          if (st_i.e_ge_lim || st_i.m_wide) begin
            cmd_o.op = cfra_pkg::OP_ERR;
            state_d  = S_DONE;
          end else begin
            state_d = S_SHL;
          end
        end else if (st_i.trunc) begin
          if (st_i.e_big) begin
            cmd_o.op = cfra_pkg::OP_ZERO_T;
            state_d  = S_DONE;
          end else begin
            state_d = S_SHR;
          end
        end else begin
          state_d = S_STRIP;
        end
      end
      // Scale up by the exponent, watching for overflow
      S_SHL: begin
        if (st_i.e_zero) begin
          cmd_o.op = st_i.trunc ? cfra_pkg::OP_TRUNC_SET : cfra_pkg::OP_CF_INIT;
          state_d  = st_i.trunc ? S_DONE : S_TERM;
        end else if (st_i.shl_ovf) begin
          cmd_o.op = cfra_pkg::OP_ERR;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = cfra_pkg::OP_SHL;
        end
      end
      // Drop fraction bits for truncation
      S_SHR: begin
        if (st_i.e_zero) begin
          cmd_o.op = st_i.m_wide ? cfra_pkg::OP_ERR : cfra_pkg::OP_TRUNC_SET;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = cfra_pkg::OP_SHR;
        end
      end
      // Strip trailing zeros into the power of two
      S_STRIP: begin
        if (st_i.e_neg && !st_i.lsb) begin
          cmd_o.op = cfra_pkg::OP_SHR;
        end else if (st_i.m_wide || st_i.nchk_err) begin
          cmd_o.op = cfra_pkg::OP_ERR;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = cfra_pkg::OP_CF_INIT;
          state_d  = S_TERM;
        end
      end
      S_TERM: begin
        if (st_i.n_zero) begin
          cmd_o.op = cfra_pkg::OP_TERM;
          state_d  = S_TEST;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (st_i.div_done) begin
          cmd_o.op = cfra_pkg::OP_TERM;
          state_d  = S_TEST;
        end
      end
      S_TEST: begin
        if (!st_i.i_zero && st_i.a_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = cfra_pkg::MUL_A_K1;
          state_d         = S_MULO;
        end
      end
      S_MULO: begin
        cmd_o.mul_sel = cfra_pkg::MUL_A_K1;
        if (st_i.mul_done) begin
          state_d = S_OVER;
        end
      end
      // Bound check on the new denominator
      S_OVER: begin
        if (!st_i.over) begin
          cmd_o.op = cfra_pkg::OP_X_A;
          state_d  = S_HSTART;
        end else if (st_i.x_ok) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cfra_pkg::DIV_BOUND;
          state_d         = S_XDIV;
        end else begin
          cmd_o.op = cfra_pkg::OP_X_ZERO;
          state_d  = S_LAST;
        end
      end
      S_XDIV: begin
        cmd_o.div_sel = cfra_pkg::DIV_BOUND;
        if (st_i.div_done) begin
          cmd_o.op = cfra_pkg::OP_X_DIV;
          state_d  = S_LAST;
        end
      end
      // Take the semi-convergent or keep the last convergent
      S_LAST: begin
        if (st_i.last_ok) begin
          cmd_o.op = cfra_pkg::OP_SET_LAST;
          state_d  = S_HSTART;
        end else begin
          state_d = S_DONE;
        end
      end
      S_HSTART: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = cfra_pkg::MUL_X_H1;
        state_d         = S_HWAIT;
      end
      S_HWAIT: begin
        cmd_o.mul_sel = cfra_pkg::MUL_X_H1;
        if (st_i.mul_done) begin
          cmd_o.op = cfra_pkg::OP_H;
          state_d  = S_KSTART;
        end
      end
      S_KSTART: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = cfra_pkg::MUL_X_K1;
        state_d         = S_KWAIT;
      end
      S_KWAIT: begin
        cmd_o.mul_sel = cfra_pkg::MUL_X_K1;
        if (st_i.mul_done) begin
          cmd_o.op = cfra_pkg::OP_K;
          state_d  = (st_i.last_q || st_i.i_last) ? S_DONE : S_TERM;
        end
      end
      // Hand the word to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = cfra_pkg::OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.op == cfra_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/continued_fraction_rational_approx_unit.sv
// Best rational approximation of a binary64 value with a bounded denominator.
//
// Input channel: in_valid_i / in_ready_o carry one word, value_bits_i, the raw
// binary64 pattern. Output channel: out_valid_o / out_ready_i carry one word of
// numerator_o, denominator_o and range_error_o for every input word.
// max_denominator_we_i writes max_denominator_i into the bound register; write it
// only while no word is in flight. A bound of 0 or 1 truncates to an integer.
//
// One word is worked at a time. Decode shifts one bit per cycle. Each
// continued-fraction term then uses the shared radix-2 divider and three
// multiplies on one 32x32 multiplier; the final semi-convergent adds one more
// division. At most MAX_TERMS terms, 64 by default, are worked per word.
//
// Reset clears the controller and the output valid and loads the bound with
// 2147483647. When the receiver stalls, the result holds in the output register
// and the block still accepts and works the next word; that word waits at its
// end until the register frees.
module continued_fraction_rational_approx_unit #(
  parameter int WORD_W    = cfra_pkg::WORD_W_DEF,
  parameter int MAX_TERMS = cfra_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cfra_pkg::VAL_W-1:0]        value_bits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cfra_pkg::NUM_W-1:0] numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]        denominator_o,
  output logic                              range_error_o,
  input  logic                              max_denominator_we_i,
  input  logic [cfra_pkg::DEN_W-1:0]        max_denominator_i
);

  logic [cfra_pkg::DEN_W-1:0] md_q;
  cfra_pkg::cmd_t             cmd;
  cfra_pkg::status_t          st;

  // Hold the denominator bound
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= cfra_pkg::MD_RESET;
    end else if (max_denominator_we_i) begin
      md_q <= max_denominator_i;
    end
  end

  cfra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  cfra_dp #(
    .W         (WORD_W),
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .value_bits_i  (value_bits_i),
    .md_i          (md_q),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o),
    .range_error_o (range_error_o)
  );

endmodule

FILE: rtl/cfra_checker.sv
module cfra_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [cfra_pkg::VAL_W-1:0]        value_bits_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cfra_pkg::NUM_W-1:0] numerator_o,
  input logic [cfra_pkg::DEN_W-1:0]        denominator_o,
  input logic                              range_error_o,
  input logic                              max_denominator_we_i,
  input logic [cfra_pkg::DEN_W-1:0]        max_denominator_i
);

  // One word at a time: an accepted word blocks the next cycle
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word was in work");

  // Range errors give zero over one
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> numerator_o == '0 && denominator_o == 1)
    else $error("range error with a nonzero result");

  // Denominator is never zero
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> denominator_o != '0)
    else $error("zero denominator");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(numerator_o) &&
      $stable(denominator_o) && $stable(range_error_o))
    else $error("stalled result changed");

endmodule

bind continued_fraction_rational_approx_unit cfra_checker u_cfra_checker (.*);

FILE: verif/continued_fraction_rational_approx_unit_tb.sv
module continued_fraction_rational_approx_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               VAL_W         = cfra_pkg::VAL_W;
  localparam int               NUM_W         = cfra_pkg::NUM_W;
  localparam int               DEN_W         = cfra_pkg::DEN_W;
  localparam int               MAX_TERMS_DEF = cfra_pkg::MAX_TERMS_DEF;
  localparam int               EXP_SUBNORM   = cfra_pkg::EXP_SUBNORM;
  localparam int               EXP_BIAS      = cfra_pkg::EXP_BIAS;
  localparam logic [10:0]      EXPF_SPECIAL  = cfra_pkg::EXPF_SPECIAL;
  localparam logic [DEN_W-1:0] MD_RESET      = cfra_pkg::MD_RESET;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    err;
  } approx_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [VAL_W-1:0]        value_bits_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [NUM_W-1:0] numerator_o;
  logic [DEN_W-1:0]        denominator_o;
  logic                    range_error_o;
  logic                    max_denominator_we_i = 1'b0;
  logic [DEN_W-1:0]        max_denominator_i = '0;

  approx_t          approx_q[$];
  logic [DEN_W-1:0] bound_shadow = MD_RESET;
  int               n_errors = 0;
  int               hold_req = 0;
  bit               calm = 1'b0;

  continued_fraction_rational_approx_unit u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .value_bits_i         (value_bits_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .numerator_o          (numerator_o),
    .denominator_o        (denominator_o),
    .range_error_o        (range_error_o),
    .max_denominator_we_i (max_denominator_we_i),
    .max_denominator_i    (max_denominator_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int bit_len(logic [63:0] v);
    int b;
    b = 0;
    for (int i = 0; i < 64; i++) if (v[i]) b = i + 1;
    return b;
  endfunction

  // Compute the bounded best rational approximation of one binary64 word
  function automatic approx_t best_rational(logic [63:0] bits, logic [DEN_W-1:0] bound);
    approx_t     res;
    logic        neg;
    logic [10:0] expf;
    logic [63:0] m, t, d, n, md, a, r, x, h0, h1, k0, k1, h2, k2;
    int          e;
    bit          over, last;
    neg  = bits[63];
    expf = bits[62:52];
    md   = 64'(bound);
    res  = '{num: '0, den: DEN_W'(1), err: 1'b1};
    if (expf == EXPF_SPECIAL) return res;
    if (expf == 0) begin
      m = {12'd0, bits[51:0]};
      e = EXP_SUBNORM;
    end else begin
      m = {11'd0, 1'b1, bits[51:0]};
      e = int'(expf) - EXP_BIAS;
    end
    // Truncating mode: integer part over one
    if (md <= 1) begin
      if (m == 0) t = 0;
      else if (e >= 0) begin
        if (bit_len(m) + e > 63) return res;
        t = m << e;
      end else begin
        t = (-e >= 64) ? 64'd0 : (m >> (-e));
        if (bit_len(t) > 63) return res;
      end
      res.num = neg ? -t : t;
      res.err = 1'b0;
      return res;
    end
    // Exact form D / N
    if (m == 0) begin
      d = 0;
      n = 1;
    end else if (e >= 0) begin
      if (bit_len(m) + e > 63) return res;
      d = m << e;
      n = 1;
    end else begin
      while (m[0] == 1'b0 && e < 0) begin
        m = m >> 1;
        e++;
      end
      if (bit_len(m) > 63) return res;
      if (e < 0) begin
        if (-e > 62) return res;
        n = 64'd1 << (-e);
      end else n = 1;
      d = m;
    end
    h0 = 0; h1 = 1; k0 = 1; k1 = 0;
    for (int i = 0; i < MAX_TERMS_DEF; i++) begin
      a = (n != 0) ? d / n : 64'd0;
      last = 1'b0;
      if (i != 0 && a == 0) break;
      r = (n != 0) ? d % n : 64'd0;
      d = n;
      n = r;
      x = a;
      if (k1 == 0) over = (k0 >= md);
      else if (k0 >= md) over = 1'b1;
      else over = a > (md - k0 - 64'd1) / k1;
      if (over) begin
        x = (k1 != 0 && md > k0) ? (md - k0) / k1 : 64'd0;
        if (x >= a - x || k1 >= md) last = 1'b1;
        else break;
      end
      h2 = x * h1 + h0; h0 = h1; h1 = h2;
      k2 = x * k1 + k0; k0 = k1; k1 = k2;
      if (last) break;
    end
    res.num = neg ? -h1 : h1;
    res.den = k1[DEN_W-1:0];
    res.err = 1'b0;
    return res;
  endfunction

  function automatic int rand_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(80, 8);
  endfunction

  // Pick a binary64 pattern, mostly values with useful expansions
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(9);
    case (sel)
      0, 1: ;
      2, 3, 4: v[62:52] = 11'($urandom_range(1023 + 40, 1023 - 40));
      5: v[62:52] = 11'($urandom_range(1023 + 62, 1023));
      6: begin
        v[62:52] = 11'($urandom_range(1023 + 12, 1023 - 8));
        v[51:0]  = v[51:0] & ~(52'hf_ffff_ffff_ffff >> $urandom_range(52));
      end
      7: v[62:52] = 11'($urandom_range(1023 - 55, 1023 - 66));
      8: v[62:52] = ($urandom_range(1)) ? 11'd0 : EXPF_SPECIAL;
      default: v[62:52] = 11'($urandom_range(2046, 1));
    endcase
    return v;
  endfunction

  // Offer one word after a gap; valid stays high when the gap is zero
  task automatic send_word(logic [63:0] bits, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= bits;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) begin
        approx_q = {approx_q, best_rational(bits, bound_shadow)};
        @(posedge clk_i);
        break;
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (approx_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_bound(logic [DEN_W-1:0] v);
    drain();
    max_denominator_we_i <= 1'b1;
    max_denominator_i    <= v;
    bound_shadow = v;
    @(posedge clk_i);
    max_denominator_we_i <= 1'b0;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_word(rand_value(), rand_gap());
  endtask

  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3ff0_0000_0000_0000,
             64'hbff0_0000_0000_0000, 64'h3fe0_0000_0000_0000, 64'h4009_21fb_5444_2d18,
             64'hc009_21fb_5444_2d18, 64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0000,
             64'hfff0_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
             64'h7fef_ffff_ffff_ffff, 64'h43d0_0000_0000_0000, 64'h43e0_0000_0000_0000,
             64'h3fd5_5555_5555_5555, 64'h3c20_0000_0000_0000, 64'h3c10_0000_0000_0000,
             64'h3ff9_e377_9b97_f4a8, 64'h3fef_ffff_ffff_ffff, 64'h43cf_ffff_ffff_ffff};
    foreach (vals[i]) send_word(vals[i], rand_gap());
  endtask

  // Sweep bounds, truncation and the extremes among them
  task automatic test_bounds();
    logic [DEN_W-1:0] bounds[$];
    bounds = '{DEN_W'(0), DEN_W'(1), DEN_W'(2), {DEN_W{1'b1}}, DEN_W'(10),
               DEN_W'({$urandom, $urandom}), DEN_W'($urandom_range(1000, 3)), MD_RESET};
    foreach (bounds[i]) begin
      set_bound(bounds[i]);
      if (i == 3) send_word(64'h3ff9_e377_9b97_f4a8, 0);
      send_random(13);
    end
  endtask

  // Stall the receiver long enough that the input backs up
  task automatic test_backpressure();
    drain();
    hold_req = 15000;
    for (int i = 0; i < 4; i++) send_word(rand_value(), 0);
    drain();
  endtask

  // Run without idling, pause the sender until all results are in, then send ten more at random gaps
  task automatic test_streaming();
    calm = 1'b1;
    send_random(10);
    calm = 1'b0;
    drain();
    send_random(10);
  endtask

  // Drive out_ready with random stalls and requested long holds
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_req - 1) @(posedge clk_i);
        hold_req = 0;
      end else begin
        g = rand_gap();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  initial begin
    approx_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (approx_q.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d err=%0b", $time,
                   numerator_o, denominator_o, range_error_o);
          n_errors++;
        end else begin
          want = approx_q.pop_front();
          if (numerator_o !== want.num) begin
            $display("%0t: numerator expected %0d actual %0d", $time, want.num, numerator_o);
            n_errors++;
          end
          if (denominator_o !== want.den) begin
            $display("%0t: denominator expected %0d actual %0d", $time, want.den,
                     denominator_o);
            n_errors++;
          end
          if (range_error_o !== want.err) begin
            $display("%0t: range_error expected %0b actual %0b", $time, want.err,
                     range_error_o);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_bounds();
    test_backpressure();
    test_streaming();
    drain();
    repeat (200) @(posedge clk_i);
    if (approx_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, approx_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/cfra_pkg.sv
rtl/cfra_div.sv
rtl/cfra_mul.sv
rtl/cfra_dp.sv
rtl/cfra_ctrl.sv
rtl/continued_fraction_rational_approx_unit.sv
rtl/cfra_checker.sv
verif/continued_fraction_rational_approx_unit_tb.sv
